@@ design/tcmab_pkg.sv @@
// Shared types and constants for the three-channel moving average with decimal readout.
package tcmab_pkg;

  // Request opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // Field widths of the words on both channels
  localparam int SAMPLE_W = 12;
  localparam int CHAN_W   = 2;
  localparam int MEAN_W   = 12;
  localparam int DIGIT_W  = 6;

  // Width of a place counter (thousands count reaches 65 at 16-bit samples)
  localparam int CNT_W = 7;

  localparam logic [DIGIT_W-1:0] ASCII_ZERO = 6'h30;

  // Decimal places walked by the digit loop
  localparam logic [1:0] PLACE_THOUSANDS = 2'd0;
  localparam logic [1:0] PLACE_HUNDREDS  = 2'd1;
  localparam logic [1:0] PLACE_TENS      = 2'd2;

  typedef struct packed {
    logic                opcode;
    logic [SAMPLE_W-1:0] sample;
  } req_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  channel;
    logic [MEAN_W-1:0]  mean;
    logic [DIGIT_W-1:0] digit_thousands;
    logic [DIGIT_W-1:0] digit_hundreds;
    logic [DIGIT_W-1:0] digit_tens;
    logic [DIGIT_W-1:0] digit_ones;
    logic               last;
  } rsp_word_t;

  // Value subtracted at each decimal place
  function automatic logic [9:0] place_value(input logic [1:0] place);
    logic [9:0] v;
    case (place)
      PLACE_THOUSANDS: v = 10'd1000;
      PLACE_HUNDREDS:  v = 10'd100;
      default:         v = 10'd10;
    endcase
    return v;
  endfunction

endpackage

@@ design/three_channel_moving_average_bcd_core.sv @@
// Top level: per-channel boxcar windows, report sequencer with one shared subtractor.
//
//  channel | dir | handshake            | word
//  --------+-----+----------------------+---------------------------------------
//  req     | in  | req_valid, req_stall | opcode, sample
//  rsp     | out | rsp_valid, rsp_stall | channel, mean, four ASCII digits, last
//
// A sample word gives no result. A report word gives one result per channel;
// each sums the window (one memory read per cycle), scales the sum by the
// reciprocal of WINDOW_DEPTH, then finds the digits by repeated subtraction
// in the digit loop on the shared subtractor and holds the result in rsp.
// After reset all NUM_CHANNELS*WINDOW_DEPTH window memory entries are zeroed,
// one entry a cycle, with req_stall high. A stalled result holds rsp and the
// sequencer until it is taken.
module three_channel_moving_average_bcd_core #(
  parameter int WINDOW_DEPTH = 8,
  parameter int NUM_CHANNELS = 3,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  tcmab_pkg::req_word_t req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output tcmab_pkg::rsp_word_t rsp
);

  localparam int DEPTH = NUM_CHANNELS * WINDOW_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PW    = $clog2(WINDOW_DEPTH);
  localparam int IW    = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int UW    = ((SAMPLE_BITS > 10) ? SAMPLE_BITS : 10) + 1;

  // Rounded-up reciprocal of the depth; exact floor for every SUM_W-bit sum
  localparam int     RSH     = SUM_W + PW;
  localparam int     RW      = SUM_W + 2;
  localparam int     PRW     = SUM_W + RW;
  localparam longint RECIP_L = ((longint'(1) << RSH) + longint'(WINDOW_DEPTH) - longint'(1))
                               / longint'(WINDOW_DEPTH);
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;
  localparam logic [2:0] ST_HOLD  = 3'd5;

  logic [2:0]             state;
  logic [AW-1:0]          addr;
  logic [CH_W-1:0]        next_ch;
  logic [PW-1:0]          pos [NUM_CHANNELS];
  logic [CH_W-1:0]        rep_ch;
  logic [IW-1:0]          idx;
  logic [SUM_W-1:0]       acc;
  logic [SAMPLE_BITS-1:0] mean;
  logic [SAMPLE_BITS-1:0] rest;
  logic [1:0]             place;
  logic [tcmab_pkg::CNT_W-1:0] cnt;
  logic [tcmab_pkg::DIGIT_W-1:0] dig_th;
  logic [tcmab_pkg::DIGIT_W-1:0] dig_hu;
  tcmab_pkg::rsp_word_t   rsp_q;

  // Window memory
  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata;

  logic                   req_take;
  logic [SAMPLE_BITS+tcmab_pkg::SAMPLE_W-1:0] samp_ext;
  logic [SAMPLE_BITS-1:0] samp;

  // Mean by reciprocal multiply
  logic [PRW-1:0]         prod;
  logic [SAMPLE_BITS-1:0] quot;

  // Shared subtractor
  logic [UW-1:0] sub_a;
  logic [UW-1:0] sub_b;
  logic [UW:0]   sub_diff;
  logic          borrow;

  // Output field shaping
  logic [CH_W+1:0]               ch_ext;
  logic [SAMPLE_BITS+11:0]       mean_ext;
  logic [tcmab_pkg::DIGIT_W-1:0] dig_te;
  logic [tcmab_pkg::DIGIT_W-1:0] dig_on;

  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_valid = (state == ST_HOLD);
  assign rsp       = rsp_q;

  assign samp_ext = {{SAMPLE_BITS{1'b0}}, req.sample};
  assign samp     = samp_ext[SAMPLE_BITS-1:0];

  // Write port: zeroing sweep or incoming sample
  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = addr;
      mem_wdata = '0;
    end else begin
      mem_we    = req_take && (req.opcode == tcmab_pkg::OP_SAMPLE);
      mem_waddr = AW'(int'(next_ch) * WINDOW_DEPTH + int'(pos[next_ch]));
      mem_wdata = samp;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[addr];
  end

  // Window sum times reciprocal, quotient in the top bits
  assign prod = {{RW{1'b0}}, acc} * {{SUM_W{1'b0}}, RECIP};
  assign quot = prod[RSH +: SAMPLE_BITS];

  // Subtractor operands: remaining value and current place
  assign sub_a    = UW'(rest);
  assign sub_b    = UW'(tcmab_pkg::place_value(place));
  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow   = sub_diff[UW];

  assign ch_ext   = {2'b00, rep_ch};
  assign mean_ext = {12'd0, mean};
  assign dig_te   = tcmab_pkg::ASCII_ZERO + cnt[tcmab_pkg::DIGIT_W-1:0];
  assign dig_on   = tcmab_pkg::ASCII_ZERO + {2'b00, rest[3:0]};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      addr    <= '0;
      next_ch <= '0;
      rep_ch  <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        pos[c] <= '0;
      end
    end else begin
      case (state)
        ST_CLEAR: begin
          if (addr == AW'(DEPTH - 1)) begin
            addr  <= '0;
            state <= ST_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (req_take) begin
            if (req.opcode == tcmab_pkg::OP_SAMPLE) begin
              pos[next_ch] <= (pos[next_ch] == PW'(WINDOW_DEPTH - 1)) ? '0
                                                                      : pos[next_ch] + 1'b1;
              next_ch <= (next_ch == CH_W'(NUM_CHANNELS - 1)) ? '0 : next_ch + 1'b1;
            end else begin
              addr   <= '0;
              rep_ch <= '0;
              idx    <= '0;
              acc    <= '0;
              state  <= ST_SUM;
            end
          end
        end
        // one read per cycle, data lands in the following cycle
        ST_SUM: begin
          if (idx != '0) begin
            acc <= acc + SUM_W'(rd_data);
          end
          if (idx == IW'(WINDOW_DEPTH)) begin
            state <= ST_DIV;
          end else begin
            addr <= addr + 1'b1;
            idx  <= idx + 1'b1;
          end
        end
        // floor of sum over depth, digit loop starts at thousands
        ST_DIV: begin
          mean  <= quot;
          rest  <= quot;
          place <= tcmab_pkg::PLACE_THOUSANDS;
          cnt   <= '0;
          state <= ST_DIGIT;
        end
        // repeated subtraction of 1000, 100, 10
        ST_DIGIT: begin
          if (!borrow) begin
            rest <= sub_diff[SAMPLE_BITS-1:0];
            cnt  <= cnt + 1'b1;
          end else begin
            cnt <= '0;
            case (place)
              tcmab_pkg::PLACE_THOUSANDS: begin
                dig_th <= tcmab_pkg::ASCII_ZERO + cnt[tcmab_pkg::DIGIT_W-1:0];
                place  <= tcmab_pkg::PLACE_HUNDREDS;
              end
              tcmab_pkg::PLACE_HUNDREDS: begin
                dig_hu <= tcmab_pkg::ASCII_ZERO + cnt[tcmab_pkg::DIGIT_W-1:0];
                place  <= tcmab_pkg::PLACE_TENS;
              end
              default: begin
                rsp_q.channel         <= ch_ext[1:0];
                rsp_q.mean            <= mean_ext[11:0];
                rsp_q.digit_thousands <= dig_th;
                rsp_q.digit_hundreds  <= dig_hu;
                rsp_q.digit_tens      <= dig_te;
                rsp_q.digit_ones      <= dig_on;
                rsp_q.last            <= (rep_ch == CH_W'(NUM_CHANNELS - 1));
                state                 <= ST_HOLD;
              end
            endcase
          end
        end
        ST_HOLD: begin
          if (!rsp_stall) begin
            if (rep_ch == CH_W'(NUM_CHANNELS - 1)) begin
              state <= ST_IDLE;
            end else begin
              rep_ch <= rep_ch + 1'b1;
              idx    <= '0;
              acc    <= '0;
              state  <= ST_SUM;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A report request starts the sum of the first channel
  a_report_start: assert property (@(posedge clk) disable iff (rst)
    (req_take && req.opcode == tcmab_pkg::OP_REPORT) |=> (state == ST_SUM && rep_ch == '0))
    else $error("report did not start at the first channel");

  // Flag last only on the final channel
  a_last_chan: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.last == (rep_ch == CH_W'(NUM_CHANNELS - 1))))
    else $error("last flag does not match channel");

  // Ones digit is always a decimal ASCII digit
  a_ones_digit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.digit_ones >= tcmab_pkg::ASCII_ZERO &&
                   rsp.digit_ones <= tcmab_pkg::ASCII_ZERO + 6'd9))
    else $error("ones digit out of range");

  // A taken non-final result moves on to the next channel
  a_next_chan: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_stall && !rsp.last) |=> (state == ST_SUM))
    else $error("sequencer did not move to next channel");

endmodule
